@@ sv/separator_batch_sequencer_core_macros.svh @@
// ----------------------------------------------------------------------------
// Separator batch sequencer assertion macros
// Shared property shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef SEPARATOR_BATCH_SEQUENCER_CORE_MACROS_SVH
`define SEPARATOR_BATCH_SEQUENCER_CORE_MACROS_SVH

// same-cycle implication
`define SBS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("separator batch sequencer check failed");

// next-cycle implication
`define SBS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("separator batch sequencer check failed");

`endif

@@ sv/sbs_pkg.sv @@
// ----------------------------------------------------------------------------
// Separator batch sequencer package
// Types, register indexes, relay positions and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package sbs_pkg;

   localparam int unsigned TIMER_WIDTH_DEF = 24;
   localparam int unsigned CFG_W           = 24;
   localparam int unsigned RELAY_W         = 8;
   localparam int unsigned PHASE_CODE_W    = 3;
   localparam int unsigned CSR_INDEX_W     = 2;

   localparam logic [CFG_W-1:0] MIXER_OFF_RST = 24'd6000;
   localparam logic [CFG_W-1:0] MIXER_ON_RST  = 24'd600;
   localparam logic [CFG_W-1:0] DRYING_RST    = 24'd36000;
   localparam logic [CFG_W-1:0] DISCHARGE_RST = 24'd50;

   localparam int unsigned RLY_SUMP    = 0;
   localparam int unsigned RLY_TOPGATE = 1;
   localparam int unsigned RLY_PRESS   = 2;
   localparam int unsigned RLY_MIXER   = 3;
   localparam int unsigned RLY_HEATER  = 4;
   localparam int unsigned RLY_BOTGATE = 5;
   localparam int unsigned RLY_SETTLE  = 6;
   localparam int unsigned RLY_FILTER  = 7;

   localparam logic [PHASE_CODE_W-1:0] PHASE_CODE_IDLE  = 3'd0;
   localparam logic [PHASE_CODE_W-1:0] PHASE_CODE_FILL  = 3'd1;
   localparam logic [PHASE_CODE_W-1:0] PHASE_CODE_PRESS = 3'd2;
   localparam logic [PHASE_CODE_W-1:0] PHASE_CODE_DRY   = 3'd3;
   localparam logic [PHASE_CODE_W-1:0] PHASE_CODE_DISCH = 3'd4;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MIXER_OFF = 2'd0,
      CSR_MIXER_ON  = 2'd1,
      CSR_DRYING    = 2'd2,
      CSR_DISCHARGE = 2'd3
   } csr_index_type;

   typedef enum logic [4:0] {
      PH_IDLE  = 5'b00001,
      PH_FILL  = 5'b00010,
      PH_PRESS = 5'b00100,
      PH_DRY   = 5'b01000,
      PH_DISCH = 5'b10000
   } phase_type;

   typedef struct packed {
      logic start_request;
      logic stop_request;
      logic input_tank_lower;
      logic input_tank_upper;
      logic mixer_full;
      logic settle_high;
      logic settle_low;
      logic filt_high;
      logic filt_low;
   } switch_type;

   typedef struct packed {
      logic [CFG_W-1:0] mixer_off_ticks;
      logic [CFG_W-1:0] mixer_on_ticks;
      logic [CFG_W-1:0] drying_ticks;
      logic [CFG_W-1:0] discharge_ticks;
   } cfg_type;

   typedef struct packed {
      phase_type          phase;
      logic [RELAY_W-1:0] relays;
      logic               mixer_active;
   } ctl_type;

   function automatic logic hyst(input logic running, input logic on_sw, input logic off_sw);
      logic result;
      result = running;
      if (!running && on_sw) begin
         result = 1'b1;
      end else if (running && off_sw) begin
         result = 1'b0;
      end
      return result;
   endfunction

   function automatic logic [PHASE_CODE_W-1:0] phase_code_of(input phase_type ph);
      logic [PHASE_CODE_W-1:0] code;
      unique case (ph)
         PH_FILL:  code = PHASE_CODE_FILL;
         PH_PRESS: code = PHASE_CODE_PRESS;
         PH_DRY:   code = PHASE_CODE_DRY;
         PH_DISCH: code = PHASE_CODE_DISCH;
         default:  code = PHASE_CODE_IDLE;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

@@ sv/sbs_csr.sv @@
// ----------------------------------------------------------------------------
// Separator batch sequencer control registers
// Four timing registers written through the csr_ channel.
// ----------------------------------------------------------------------------
`default_nettype none

module sbs_csr (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   csr_valid,
   input  wire  [sbs_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire  [sbs_pkg::CFG_W-1:0]             csr_wdata,
   output sbs_pkg::cfg_type                      cfg
);

   sbs_pkg::cfg_type cfg_ff;
   sbs_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (sbs_pkg::csr_index_type'(csr_index))
            sbs_pkg::CSR_MIXER_OFF: cfg_in.mixer_off_ticks = csr_wdata;
            sbs_pkg::CSR_MIXER_ON:  cfg_in.mixer_on_ticks  = csr_wdata;
            sbs_pkg::CSR_DRYING:    cfg_in.drying_ticks    = csr_wdata;
            sbs_pkg::CSR_DISCHARGE: cfg_in.discharge_ticks = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mixer_off_ticks <= sbs_pkg::MIXER_OFF_RST;
         cfg_ff.mixer_on_ticks  <= sbs_pkg::MIXER_ON_RST;
         cfg_ff.drying_ticks    <= sbs_pkg::DRYING_RST;
         cfg_ff.discharge_ticks <= sbs_pkg::DISCHARGE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ sv/sbs_step.sv @@
// ----------------------------------------------------------------------------
// Separator batch sequencer tick logic
// Next phase, relays and timers for one control tick.
// ----------------------------------------------------------------------------
`default_nettype none

module sbs_step #(
   parameter int unsigned TIMER_WIDTH = sbs_pkg::TIMER_WIDTH_DEF
) (
   input  sbs_pkg::ctl_type         cur_ctl,
   input  wire  [TIMER_WIDTH-1:0]   cur_phase_elapsed,
   input  wire  [TIMER_WIDTH-1:0]   cur_mixer_elapsed,
   input  sbs_pkg::switch_type      sw,
   input  sbs_pkg::cfg_type         cfg,
   output sbs_pkg::ctl_type         nxt_ctl,
   output logic [TIMER_WIDTH-1:0]   nxt_phase_elapsed,
   output logic [TIMER_WIDTH-1:0]   nxt_mixer_elapsed
);

   localparam int unsigned CMP_W =
      (TIMER_WIDTH > sbs_pkg::CFG_W) ? TIMER_WIDTH : sbs_pkg::CFG_W;
   localparam logic [TIMER_WIDTH-1:0] T_ZERO = '0;
   localparam logic [TIMER_WIDTH-1:0] T_ONE  = TIMER_WIDTH'(1);

   logic [TIMER_WIDTH-1:0]      pe_bump;
   logic [TIMER_WIDTH-1:0]      me_bump;
   logic [sbs_pkg::RELAY_W-1:0] rel_pump;
   logic                        mt_active;
   logic [TIMER_WIDTH-1:0]      mt_elapsed;
   logic                        mt_mixer;
   logic                        dry_done;
   logic                        disch_done;

   assign pe_bump = (&cur_phase_elapsed) ? cur_phase_elapsed : cur_phase_elapsed + T_ONE;
   assign me_bump = (&cur_mixer_elapsed) ? cur_mixer_elapsed : cur_mixer_elapsed + T_ONE;

   assign dry_done   = CMP_W'(pe_bump) >= CMP_W'(cfg.drying_ticks);
   assign disch_done = CMP_W'(pe_bump) >= CMP_W'(cfg.discharge_ticks);

   // settling and filter pumps
   always_comb begin
      rel_pump = cur_ctl.relays;
      rel_pump[sbs_pkg::RLY_SETTLE] = sbs_pkg::hyst(cur_ctl.relays[sbs_pkg::RLY_SETTLE],
                                                    sw.settle_high, sw.settle_low);
      rel_pump[sbs_pkg::RLY_FILTER] = sbs_pkg::hyst(cur_ctl.relays[sbs_pkg::RLY_FILTER],
                                                    sw.filt_high, sw.filt_low);
   end

   // mixer duty cycle
   always_comb begin
      mt_active  = cur_ctl.mixer_active;
      mt_elapsed = me_bump;
      mt_mixer   = cur_ctl.relays[sbs_pkg::RLY_MIXER];
      if (!cur_ctl.mixer_active) begin
         if (CMP_W'(me_bump) >= CMP_W'(cfg.mixer_off_ticks)) begin
            mt_active  = 1'b1;
            mt_elapsed = T_ZERO;
            mt_mixer   = 1'b1;
         end
      end else if (CMP_W'(me_bump) >= CMP_W'(cfg.mixer_on_ticks)) begin
         mt_active  = 1'b0;
         mt_elapsed = T_ZERO;
         mt_mixer   = 1'b0;
      end
   end

   always_comb begin
      nxt_ctl           = cur_ctl;
      nxt_phase_elapsed = cur_phase_elapsed;
      nxt_mixer_elapsed = cur_mixer_elapsed;
      if (sw.stop_request) begin
         nxt_ctl.phase     = sbs_pkg::PH_IDLE;
         nxt_ctl.relays    = '0;
         nxt_phase_elapsed = T_ZERO;
      end else begin
         unique case (cur_ctl.phase)
            sbs_pkg::PH_FILL: begin
               nxt_ctl.relays    = rel_pump;
               nxt_phase_elapsed = pe_bump;
               if (sw.input_tank_upper) begin
                  nxt_ctl.phase                         = sbs_pkg::PH_PRESS;
                  nxt_phase_elapsed                     = T_ZERO;
                  nxt_ctl.relays[sbs_pkg::RLY_SUMP]     = 1'b0;
                  nxt_ctl.relays[sbs_pkg::RLY_TOPGATE]  = 1'b1;
                  nxt_ctl.relays[sbs_pkg::RLY_PRESS]    = 1'b1;
                  nxt_mixer_elapsed                     = T_ZERO;
                  nxt_ctl.mixer_active                  = 1'b0;
               end
            end
            sbs_pkg::PH_PRESS: begin
               nxt_ctl.relays                     = rel_pump;
               nxt_phase_elapsed                  = pe_bump;
               nxt_ctl.mixer_active               = mt_active;
               nxt_mixer_elapsed                  = mt_elapsed;
               nxt_ctl.relays[sbs_pkg::RLY_MIXER] = mt_mixer;
               nxt_ctl.relays[sbs_pkg::RLY_SUMP]  =
                  sbs_pkg::hyst(cur_ctl.relays[sbs_pkg::RLY_SUMP],
                                sw.input_tank_lower, sw.input_tank_upper);
               if (sw.mixer_full) begin
                  nxt_ctl.phase                        = sbs_pkg::PH_DRY;
                  nxt_phase_elapsed                    = T_ZERO;
                  nxt_ctl.relays[sbs_pkg::RLY_PRESS]   = 1'b0;
                  nxt_ctl.relays[sbs_pkg::RLY_TOPGATE] = 1'b0;
                  nxt_ctl.relays[sbs_pkg::RLY_SUMP]    = 1'b0;
                  nxt_ctl.relays[sbs_pkg::RLY_MIXER]   = 1'b0;
                  nxt_ctl.relays[sbs_pkg::RLY_HEATER]  = 1'b1;
                  nxt_mixer_elapsed                    = T_ZERO;
                  nxt_ctl.mixer_active                 = 1'b0;
               end
            end
            sbs_pkg::PH_DRY: begin
               nxt_ctl.relays                     = rel_pump;
               nxt_phase_elapsed                  = pe_bump;
               nxt_ctl.mixer_active               = mt_active;
               nxt_mixer_elapsed                  = mt_elapsed;
               nxt_ctl.relays[sbs_pkg::RLY_MIXER] = mt_mixer;
               if (dry_done) begin
                  nxt_ctl.phase                        = sbs_pkg::PH_DISCH;
                  nxt_phase_elapsed                    = T_ZERO;
                  nxt_ctl.relays[sbs_pkg::RLY_HEATER]  = 1'b0;
                  nxt_ctl.relays[sbs_pkg::RLY_BOTGATE] = 1'b1;
                  nxt_ctl.relays[sbs_pkg::RLY_MIXER]   = 1'b1;
               end
            end
            sbs_pkg::PH_DISCH: begin
               nxt_ctl.relays    = rel_pump;
               nxt_phase_elapsed = pe_bump;
               if (disch_done) begin
                  nxt_ctl.phase     = sbs_pkg::PH_IDLE;
                  nxt_ctl.relays    = '0;
                  nxt_phase_elapsed = T_ZERO;
               end
            end
            default: begin
               nxt_ctl.phase = sbs_pkg::PH_IDLE;
               if (sw.start_request) begin
                  nxt_ctl.phase                     = sbs_pkg::PH_FILL;
                  nxt_phase_elapsed                 = T_ZERO;
                  nxt_ctl.relays[sbs_pkg::RLY_SUMP] = 1'b1;
               end
            end
         endcase
      end
   end

endmodule

`default_nettype wire

@@ sv/separator_batch_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// Separator batch sequencer core
// Phase sequencer, relay drive and tick timers for a solids/liquid separator.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one control tick per transfer, carrying start, stop and the
//   float-switch bits. rsp_ channel: one transfer per tick with the relay
//   drive and phase code as they stand after that tick.
//   csr_ channel: writes the four timing registers (index 0 to 3); always
//   ready; they must be written only while no tick is in flight, which the
//   block does not enforce. A req_ tick is captured in the input register;
//   the tick logic loads the result register once that register is free,
//   raising rsp_valid. Throughput: one tick per cycle while rsp_ready stays
//   high, set by the single pass through the tick logic that updates the
//   phase, relay and timer registers.
//   Reset: idle phase, all relays off, timers cleared, registers at their
//   default timings, both pipeline stages empty.
//   Stall: a held result keeps rsp_ payload steady; one more tick waits in
//   the input register, then req_ready drops until rsp_ready returns.
// ----------------------------------------------------------------------------
`default_nettype none

module separator_batch_sequencer_core #(
   parameter int unsigned TIMER_WIDTH = sbs_pkg::TIMER_WIDTH_DEF
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  wire                                  req_start_request,
   input  wire                                  req_stop_request,
   input  wire                                  req_input_tank_lower,
   input  wire                                  req_input_tank_upper,
   input  wire                                  req_mixer_full,
   input  wire                                  req_settle_high,
   input  wire                                  req_settle_low,
   input  wire                                  req_filt_high,
   input  wire                                  req_filt_low,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output logic [sbs_pkg::RELAY_W-1:0]          rsp_relay_drive,
   output logic [sbs_pkg::PHASE_CODE_W-1:0]     rsp_phase_code,
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire  [sbs_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire  [sbs_pkg::CFG_W-1:0]            csr_wdata
);

   sbs_pkg::cfg_type                  cfg;
   sbs_pkg::switch_type               sw_ff;
   sbs_pkg::switch_type               sw_in;
   logic                              s1_valid_ff;
   logic                              s1_valid_in;
   sbs_pkg::ctl_type                  ctl_ff;
   sbs_pkg::ctl_type                  ctl_in;
   logic [TIMER_WIDTH-1:0]            pe_ff;
   logic [TIMER_WIDTH-1:0]            pe_in;
   logic [TIMER_WIDTH-1:0]            me_ff;
   logic [TIMER_WIDTH-1:0]            me_in;
   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   logic [sbs_pkg::RELAY_W-1:0]       rsp_relay_ff;
   logic [sbs_pkg::RELAY_W-1:0]       rsp_relay_in;
   logic [sbs_pkg::PHASE_CODE_W-1:0]  rsp_phase_ff;
   logic [sbs_pkg::PHASE_CODE_W-1:0]  rsp_phase_in;
   sbs_pkg::ctl_type                  step_ctl;
   logic [TIMER_WIDTH-1:0]            step_pe;
   logic [TIMER_WIDTH-1:0]            step_me;
   logic                              advance;
   logic                              req_take;

   assign csr_ready = 1'b1;

   sbs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sbs_step #(
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_step (
      .cur_ctl           (ctl_ff),
      .cur_phase_elapsed (pe_ff),
      .cur_mixer_elapsed (me_ff),
      .sw                (sw_ff),
      .cfg               (cfg),
      .nxt_ctl           (step_ctl),
      .nxt_phase_elapsed (step_pe),
      .nxt_mixer_elapsed (step_me)
   );

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      sw_in        = sw_ff;
      s1_valid_in  = (s1_valid_ff && !advance) || req_take;
      ctl_in       = ctl_ff;
      pe_in        = pe_ff;
      me_in        = me_ff;
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);
      rsp_relay_in = rsp_relay_ff;
      rsp_phase_in = rsp_phase_ff;
      if (req_take) begin
         sw_in.start_request    = req_start_request;
         sw_in.stop_request     = req_stop_request;
         sw_in.input_tank_lower = req_input_tank_lower;
         sw_in.input_tank_upper = req_input_tank_upper;
         sw_in.mixer_full       = req_mixer_full;
         sw_in.settle_high      = req_settle_high;
         sw_in.settle_low       = req_settle_low;
         sw_in.filt_high        = req_filt_high;
         sw_in.filt_low         = req_filt_low;
      end
      if (advance) begin
         ctl_in       = step_ctl;
         pe_in        = step_pe;
         me_in        = step_me;
         rsp_relay_in = step_ctl.relays;
         rsp_phase_in = sbs_pkg::phase_code_of(step_ctl.phase);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff         <= 1'b0;
         rsp_valid_ff        <= 1'b0;
         ctl_ff.phase        <= sbs_pkg::PH_IDLE;
         ctl_ff.relays       <= '0;
         ctl_ff.mixer_active <= 1'b0;
         pe_ff               <= '0;
         me_ff               <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         ctl_ff       <= ctl_in;
         pe_ff        <= pe_in;
         me_ff        <= me_in;
      end
   end

   // payload: hold unless a transfer moves it
   always_ff @(posedge clock) begin
      sw_ff        <= sw_in;
      rsp_relay_ff <= rsp_relay_in;
      rsp_phase_ff <= rsp_phase_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_relay_drive = rsp_relay_ff;
   assign rsp_phase_code  = rsp_phase_ff;

endmodule

`default_nettype wire

@@ sv/sbs_checker.sv @@
// ----------------------------------------------------------------------------
// Separator batch sequencer checker
// Port-level properties of the result channel, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

`include "separator_batch_sequencer_core_macros.svh"

module sbs_checker (
   input wire                                clock,
   input wire                                reset,
   input wire                                rsp_valid,
   input wire                                rsp_ready,
   input wire [sbs_pkg::RELAY_W-1:0]         rsp_relay_drive,
   input wire [sbs_pkg::PHASE_CODE_W-1:0]    rsp_phase_code
);

   logic                                                rsp_held;
   logic [sbs_pkg::RELAY_W+sbs_pkg::PHASE_CODE_W-1:0]   rsp_word;
   logic                                                phase_known;
   logic                                                is_idle;
   logic                                                is_dry;
   logic                                                is_disch;
   logic                                                heater_on;
   logic                                                press_on;
   logic                                                botgate_on;

   assign rsp_held    = rsp_valid && !rsp_ready;
   assign rsp_word    = {rsp_relay_drive, rsp_phase_code};
   assign phase_known = (rsp_phase_code == sbs_pkg::PHASE_CODE_IDLE)  ||
                        (rsp_phase_code == sbs_pkg::PHASE_CODE_FILL)  ||
                        (rsp_phase_code == sbs_pkg::PHASE_CODE_PRESS) ||
                        (rsp_phase_code == sbs_pkg::PHASE_CODE_DRY)   ||
                        (rsp_phase_code == sbs_pkg::PHASE_CODE_DISCH);
   assign is_idle     = rsp_valid && (rsp_phase_code == sbs_pkg::PHASE_CODE_IDLE);
   assign is_dry      = rsp_valid && (rsp_phase_code == sbs_pkg::PHASE_CODE_DRY);
   assign is_disch    = rsp_valid && (rsp_phase_code == sbs_pkg::PHASE_CODE_DISCH);
   assign heater_on   = rsp_relay_drive[sbs_pkg::RLY_HEATER];
   assign press_on    = rsp_relay_drive[sbs_pkg::RLY_PRESS];
   assign botgate_on  = rsp_relay_drive[sbs_pkg::RLY_BOTGATE];

   `SBS_ASSERT_NEXT(a_rsp_hold, rsp_held, rsp_valid && $stable(rsp_word))

   `SBS_ASSERT_NOW(a_phase_range, rsp_valid, phase_known)

   `SBS_ASSERT_NOW(a_idle_relays_off, is_idle, rsp_relay_drive == '0)

   `SBS_ASSERT_NOW(a_dry_heater, is_dry, heater_on && !press_on)

   `SBS_ASSERT_NOW(a_disch_gate, is_disch, botgate_on && !heater_on)

endmodule

bind separator_batch_sequencer_core sbs_checker u_sbs_checker (.*);

`default_nettype wire

@@ dv/tb_separator_batch_sequencer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Separator batch sequencer testbench
// Sends control ticks with random handshake gaps and checks every relay
// drive and phase code against a cycle-free model of the batch sequence,
// over several timing settings written through the csr_ channel.
// ----------------------------------------------------------------------------

typedef logic [sbs_pkg::CFG_W-1:0] timing_type;

typedef struct packed {
   logic [sbs_pkg::RELAY_W-1:0]      relays;
   logic [sbs_pkg::PHASE_CODE_W-1:0] code;
} drive_word_type;

class batch_drive_board;
   sbs_pkg::cfg_type                        timing;
   logic [sbs_pkg::PHASE_CODE_W-1:0]        phase_now;
   logic [sbs_pkg::RELAY_W-1:0]             relays;
   logic [sbs_pkg::TIMER_WIDTH_DEF-1:0]     phase_ticks;
   logic [sbs_pkg::TIMER_WIDTH_DEF-1:0]     mix_ticks;
   logic                                    mix_running;
   drive_word_type                          expected_drive[$];
   int                                      mismatch_count;

   function new();
      timing.mixer_off_ticks = sbs_pkg::MIXER_OFF_RST;
      timing.mixer_on_ticks  = sbs_pkg::MIXER_ON_RST;
      timing.drying_ticks    = sbs_pkg::DRYING_RST;
      timing.discharge_ticks = sbs_pkg::DISCHARGE_RST;
      phase_now      = sbs_pkg::PHASE_CODE_IDLE;
      relays         = '0;
      phase_ticks    = '0;
      mix_ticks      = '0;
      mix_running    = 1'b0;
      mismatch_count = 0;
   endfunction

   function void set_timing(input sbs_pkg::csr_index_type idx, input timing_type value);
      case (idx)
         sbs_pkg::CSR_MIXER_OFF: timing.mixer_off_ticks = value;
         sbs_pkg::CSR_MIXER_ON:  timing.mixer_on_ticks  = value;
         sbs_pkg::CSR_DRYING:    timing.drying_ticks    = value;
         sbs_pkg::CSR_DISCHARGE: timing.discharge_ticks = value;
         default: ;
      endcase
   endfunction

   function logic [sbs_pkg::TIMER_WIDTH_DEF-1:0] count_up(
      input logic [sbs_pkg::TIMER_WIDTH_DEF-1:0] t);
      return (t == '1) ? t : t + 1'b1;
   endfunction

   // pump follows its level switches: start switch turns on, stop switch off
   function logic level_follow(input logic running, input logic start_sw,
                               input logic stop_sw);
      return running ? !stop_sw : start_sw;
   endfunction

   function void mixer_step();
      mix_ticks = count_up(mix_ticks);
      if (!mix_running) begin
         if (mix_ticks >= timing.mixer_off_ticks) begin
            mix_running = 1'b1;
            mix_ticks = '0;
            relays[sbs_pkg::RLY_MIXER] = 1'b1;
         end
      end else if (mix_ticks >= timing.mixer_on_ticks) begin
         mix_running = 1'b0;
         mix_ticks = '0;
         relays[sbs_pkg::RLY_MIXER] = 1'b0;
      end
   endfunction

   function void enter_idle();
      phase_now = sbs_pkg::PHASE_CODE_IDLE;
      phase_ticks = '0;
      relays = '0;
   endfunction

   function void note_tick(input sbs_pkg::switch_type sw);
      drive_word_type w;
      if (sw.stop_request) begin
         enter_idle();
      end else if (phase_now < sbs_pkg::PHASE_CODE_FILL ||
                   phase_now > sbs_pkg::PHASE_CODE_DISCH) begin
         phase_now = sbs_pkg::PHASE_CODE_IDLE;
         if (sw.start_request) begin
            phase_now = sbs_pkg::PHASE_CODE_FILL;
            phase_ticks = '0;
            relays[sbs_pkg::RLY_SUMP] = 1'b1;
         end
      end else begin
         phase_ticks = count_up(phase_ticks);
         relays[sbs_pkg::RLY_SETTLE] = level_follow(relays[sbs_pkg::RLY_SETTLE],
                                                    sw.settle_high, sw.settle_low);
         relays[sbs_pkg::RLY_FILTER] = level_follow(relays[sbs_pkg::RLY_FILTER],
                                                    sw.filt_high, sw.filt_low);
         case (phase_now)
            sbs_pkg::PHASE_CODE_FILL: begin
               if (sw.input_tank_upper) begin
                  phase_now = sbs_pkg::PHASE_CODE_PRESS;
                  phase_ticks = '0;
                  relays[sbs_pkg::RLY_SUMP] = 1'b0;
                  relays[sbs_pkg::RLY_TOPGATE] = 1'b1;
                  relays[sbs_pkg::RLY_PRESS] = 1'b1;
                  mix_ticks = '0;
                  mix_running = 1'b0;
               end
            end
            sbs_pkg::PHASE_CODE_PRESS: begin
               mixer_step();
               relays[sbs_pkg::RLY_SUMP] = level_follow(relays[sbs_pkg::RLY_SUMP],
                                                        sw.input_tank_lower,
                                                        sw.input_tank_upper);
               if (sw.mixer_full) begin
                  phase_now = sbs_pkg::PHASE_CODE_DRY;
                  phase_ticks = '0;
                  relays[sbs_pkg::RLY_PRESS] = 1'b0;
                  relays[sbs_pkg::RLY_TOPGATE] = 1'b0;
                  relays[sbs_pkg::RLY_SUMP] = 1'b0;
                  relays[sbs_pkg::RLY_MIXER] = 1'b0;
                  relays[sbs_pkg::RLY_HEATER] = 1'b1;
                  mix_ticks = '0;
                  mix_running = 1'b0;
               end
            end
            sbs_pkg::PHASE_CODE_DRY: begin
               mixer_step();
               if (phase_ticks >= timing.drying_ticks) begin
                  phase_now = sbs_pkg::PHASE_CODE_DISCH;
                  phase_ticks = '0;
                  relays[sbs_pkg::RLY_HEATER] = 1'b0;
                  relays[sbs_pkg::RLY_BOTGATE] = 1'b1;
                  relays[sbs_pkg::RLY_MIXER] = 1'b1;
               end
            end
            default: begin
               if (phase_ticks >= timing.discharge_ticks) enter_idle();
            end
         endcase
      end
      w.relays = relays;
      w.code = phase_now;
      expected_drive.push_back(w);
   endfunction

   task report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatch_count++;
   endtask

   task check_drive(input logic [sbs_pkg::RELAY_W-1:0] relays_seen,
                    input logic [sbs_pkg::PHASE_CODE_W-1:0] code_seen);
      drive_word_type want;
      if (expected_drive.size() == 0) begin
         report_mismatch($sformatf("unexpected result relays %h phase %0d",
                                   relays_seen, code_seen));
         return;
      end
      want = expected_drive.pop_front();
      if (relays_seen !== want.relays)
         report_mismatch($sformatf("relay_drive %h, want %h", relays_seen, want.relays));
      if (code_seen !== want.code)
         report_mismatch($sformatf("phase_code %0d, want %0d", code_seen, want.code));
   endtask
endclass

module tb_separator_batch_sequencer_core;

   localparam int STALL_LIMIT   = 4000;
   localparam int PHASE_COUNT   = 8;
   localparam int PHASE_ITEMS   = 220;
   localparam int SETTLE_CYCLES = 8;
   localparam timing_type TIMING_MAX = '1;

   // start stop itl itu mixf stu stl flu fll
   localparam logic [8:0] OPENING_TICKS [12] = '{
      9'b0_0_0000000, 9'b0_0_1111111, 9'b1_1_0000000, 9'b1_0_0000000,
      9'b1_0_0001010, 9'b0_0_0000101, 9'b0_0_0100000, 9'b0_0_1000000,
      9'b0_0_1100000, 9'b0_0_0010000, 9'b0_0_0000000, 9'b0_1_0000000
   };
   localparam logic [8:0] ZERO_TIMING_TICKS [8] = '{
      9'b1_0_0000000, 9'b0_0_0100000, 9'b0_0_0000000, 9'b0_0_0000000,
      9'b0_0_0010000, 9'b0_0_0000000, 9'b0_0_0000000, 9'b0_1_0000000
   };

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   sbs_pkg::switch_type                 req_tick;
   logic                                rsp_valid;
   logic                                rsp_ready;
   logic [sbs_pkg::RELAY_W-1:0]         rsp_relay_drive;
   logic [sbs_pkg::PHASE_CODE_W-1:0]    rsp_phase_code;
   logic                                csr_valid;
   logic                                csr_ready;
   sbs_pkg::csr_index_type              csr_index;
   timing_type                          csr_wdata;

   int send_idle_pct;
   int rcv_stall_pct;
   int quiet_cycles;

   batch_drive_board sb = new();

   separator_batch_sequencer_core DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_start_request    (req_tick.start_request),
      .req_stop_request     (req_tick.stop_request),
      .req_input_tank_lower (req_tick.input_tank_lower),
      .req_input_tank_upper (req_tick.input_tank_upper),
      .req_mixer_full       (req_tick.mixer_full),
      .req_settle_high      (req_tick.settle_high),
      .req_settle_low       (req_tick.settle_low),
      .req_filt_high        (req_tick.filt_high),
      .req_filt_low         (req_tick.filt_low),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_relay_drive      (rsp_relay_drive),
      .rsp_phase_code       (rsp_phase_code),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready <= ($urandom_range(99) >= rcv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_drive(rsp_relay_drive, rsp_phase_code);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // hold the tick until transferred; called and left at a falling edge
   task automatic send_tick(input sbs_pkg::switch_type sw);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_tick <= sw;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_tick(sw);
      @(negedge clock);
   endtask

   task automatic drain_ticks();
      req_valid <= 1'b0;
      while (sb.expected_drive.size() != 0) @(negedge clock);
   endtask

   task automatic write_timings(input sbs_pkg::cfg_type t);
      sbs_pkg::csr_index_type idx;
      timing_type value;
      for (int i = 0; i < 4; i++) begin
         idx = sbs_pkg::csr_index_type'(i);
         case (idx)
            sbs_pkg::CSR_MIXER_OFF: value = t.mixer_off_ticks;
            sbs_pkg::CSR_MIXER_ON:  value = t.mixer_on_ticks;
            sbs_pkg::CSR_DRYING:    value = t.drying_ticks;
            default:                value = t.discharge_ticks;
         endcase
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_wdata <= value;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         sb.set_timing(idx, value);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   // mostly ticks that move the batch along, with a share of pure noise
   function automatic sbs_pkg::switch_type next_switch_tick(
      input logic [sbs_pkg::PHASE_CODE_W-1:0] ph);
      sbs_pkg::switch_type sw;
      sw = sbs_pkg::switch_type'(9'($urandom_range(511)));
      if ($urandom_range(9) != 0) begin
         sw.stop_request = ($urandom_range(63) == 0);
         sw.start_request = 1'b0;
         case (ph)
            sbs_pkg::PHASE_CODE_IDLE:  sw.start_request = 1'($urandom_range(1));
            sbs_pkg::PHASE_CODE_FILL:  sw.input_tank_upper = ($urandom_range(3) == 0);
            sbs_pkg::PHASE_CODE_PRESS: sw.mixer_full = ($urandom_range(7) == 0);
            default: ;
         endcase
      end
      return sw;
   endfunction

   initial begin
      sbs_pkg::cfg_type timings;
      int k;
      int n;
      reset = 1'b1;
      req_valid = 1'b0;
      req_tick = '0;
      csr_valid = 1'b0;
      csr_index = sbs_pkg::CSR_MIXER_OFF;
      csr_wdata = '0;
      send_idle_pct = 0;
      rcv_stall_pct = 0;
      quiet_cycles = 0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (n = 0; n < 12; n++) send_tick(sbs_pkg::switch_type'(OPENING_TICKS[n]));
      drain_ticks();
      write_timings('{24'd0, 24'd0, 24'd0, 24'd0});
      for (n = 0; n < 8; n++) send_tick(sbs_pkg::switch_type'(ZERO_TIMING_TICKS[n]));

      for (k = 0; k < PHASE_COUNT; k++) begin
         drain_ticks();
         case (k)
            0: timings = '{24'd0, 24'd0, 24'd0, 24'd0};
            1: timings = '{24'd1, 24'd2, 24'd3, 24'd4};
            3: timings = '{TIMING_MAX, TIMING_MAX, TIMING_MAX, TIMING_MAX};
            4: timings = '{TIMING_MAX, 24'd3, 24'd20, 24'd5};
            6: timings = '{24'd3, TIMING_MAX, timing_type'($urandom_range(40)), TIMING_MAX};
            7: timings = '{timing_type'($urandom), timing_type'($urandom),
                           timing_type'($urandom), timing_type'($urandom)};
            default: timings = '{timing_type'($urandom_range(7)),
                                 timing_type'($urandom_range(7)),
                                 timing_type'($urandom_range(30)),
                                 timing_type'($urandom_range(15))};
         endcase
         write_timings(timings);
         case (k % 4)
            0: begin send_idle_pct = 0;  rcv_stall_pct = 0;  end
            1: begin send_idle_pct = 75; rcv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rcv_stall_pct = 75; end
            default: begin send_idle_pct = 8; rcv_stall_pct = 8; end
         endcase
         for (n = 0; n < PHASE_ITEMS; n++) send_tick(next_switch_tick(sb.phase_now));
      end

      drain_ticks();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (sb.expected_drive.size() != 0)
         sb.report_mismatch($sformatf("%0d results never arrived", sb.expected_drive.size()));
      if (sb.mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
